/* rtl/rpc_pkg.sv */
// Shared types, constants and the control-store program of the rate PI controller.
package rpc_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int GAIN_W   = 24;
    localparam int PERIOD_W = 24;
    localparam int RAW_W    = 16;
    localparam int DATA_W   = 32;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Frame match
    localparam logic [10:0] FRAME_ID_RATE  = 11'd42;
    localparam logic [3:0]  FRAME_LEN_RATE = 4'd6;

    // Item kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Drive modes
    localparam logic MODE_DISABLED = 1'b0;
    localparam logic MODE_CURRENT  = 1'b1;

    // Register reset values
    localparam logic [1:0]            AXIS_RESET    = 2'd0;
    localparam logic [PERIOD_W-1:0]   PERIOD_RESET  = 24'd839;
    localparam logic [TIME_W-1:0]     TIMEOUT_RESET = 32'd500000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_SELECT       = 3'd0,
        REG_GAIN_PROPORTIONAL = 3'd1,
        REG_GAIN_INTEGRAL     = 3'd2,
        REG_LOOP_PERIOD       = 3'd3,
        REG_TIMEOUT_US        = 3'd4
    } cfg_reg_t;

    // Input word
    typedef struct packed {
        logic                    kind;
        logic [TIME_W-1:0]       now_us;
        logic [10:0]             frame_id;
        logic [3:0]              frame_length;
        logic signed [RAW_W-1:0] rate_error_x;
        logic signed [RAW_W-1:0] rate_error_y;
        logic signed [RAW_W-1:0] rate_error_z;
        logic                    drive_saturated;
    } item_word_t;

    // Output word
    typedef struct packed {
        logic                     drive_mode;
        logic signed [DATA_W-1:0] current_reference;
    } result_word_t;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KI_ERR,
        MUL_KP_ERR,
        MUL_PHI_LP,
        MUL_PLO_LP,
        MUL_RAW_K
    } mul_sel_t;

    // Datapath operation
    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_RND16,
        ALU_LOAD_SHL20,
        ALU_ADD_PROD,
        ALU_RND24,
        ALU_INTEG,
        ALU_OUT,
        ALU_STALE,
        ALU_LOAD,
        ALU_DIVQ,
        ALU_ERR
    } alu_op_t;

    // Sequencer branch condition
    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ACCEPT,
        JMP_FRAME,
        JMP_STALE,
        JMP_SAT,
        JMP_NOMATCH,
        JMP_ALWAYS
    } jmp_t;

    typedef struct packed {
        mul_sel_t          mul;
        alu_op_t           alu;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    // Step addresses
    localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd1;
    localparam logic [STEP_W-1:0] STEP_IRND     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_PHI      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_PLO      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SUM      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_INC      = 4'd6;
    localparam logic [STEP_W-1:0] STEP_INTEG    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_PTERM    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_PRND     = 4'd9;
    localparam logic [STEP_W-1:0] STEP_OUT      = 4'd10;
    localparam logic [STEP_W-1:0] STEP_STALE    = 4'd11;
    localparam logic [STEP_W-1:0] STEP_FRAME    = 4'd12;
    localparam logic [STEP_W-1:0] STEP_FLOAD    = 4'd13;
    localparam logic [STEP_W-1:0] STEP_FDIV     = 4'd14;
    localparam logic [STEP_W-1:0] STEP_FERR     = 4'd15;

    // Control store
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '{mul: MUL_NONE, alu: ALU_NONE, jmp: JMP_NEXT, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:     begin c.jmp = JMP_ACCEPT; c.target = STEP_DISPATCH; end
            STEP_DISPATCH: begin c.mul = MUL_KI_ERR; c.jmp = JMP_FRAME; c.target = STEP_FRAME; end
            STEP_IRND:     begin c.alu = ALU_RND16; c.jmp = JMP_STALE; c.target = STEP_STALE; end
            STEP_PHI:      begin c.mul = MUL_PHI_LP; c.jmp = JMP_SAT; c.target = STEP_PTERM; end
            STEP_PLO:      begin c.mul = MUL_PLO_LP; c.alu = ALU_LOAD_SHL20; end
            STEP_SUM:      c.alu = ALU_ADD_PROD;
            STEP_INC:      c.alu = ALU_RND24;
            STEP_INTEG:    c.alu = ALU_INTEG;
            STEP_PTERM:    c.mul = MUL_KP_ERR;
            STEP_PRND:     c.alu = ALU_RND16;
            STEP_OUT:      begin c.alu = ALU_OUT; c.jmp = JMP_ALWAYS; c.target = STEP_IDLE; end
            STEP_STALE:    begin c.alu = ALU_STALE; c.jmp = JMP_ALWAYS; c.target = STEP_IDLE; end
            STEP_FRAME:    begin c.mul = MUL_RAW_K; c.jmp = JMP_NOMATCH; c.target = STEP_IDLE; end
            STEP_FLOAD:    c.alu = ALU_LOAD;
            STEP_FDIV:     c.alu = ALU_DIVQ;
            STEP_FERR:     begin c.alu = ALU_ERR; c.jmp = JMP_ALWAYS; c.target = STEP_IDLE; end
        endcase
        return c;
    endfunction

endpackage

/* rtl/rate_pi_current_controller.sv */
// Top level: microcoded PI current controller driven by rate-error frames.
//
// Usage
//   Input channel (item_valid / item_stall / item): one word is either a
//   received frame (kind 0) or a control tick (kind 1). A frame with id 42
//   and length 6 loads the selected axis rate error and the command time.
//   Each tick returns one result word (result_valid / result_stall / result)
//   with the drive mode and the Q16.16 current reference; frames return none.
//   Configuration: cfg_write, cfg_index and cfg_data write one register per
//   clock; write only while the block is idle.
// Timing
//   A full tick runs from acceptance to the result register but skips the
//   integrator steps while the drive saturates; a stale command jumps to
//   its result step. item_stall stays high meanwhile. The rate is set by the
//   16-step control program and the single shared 33x25 multiplier.
// Reset
//   rst_n clears the sequencer, the result valid flag, the error, integrator
//   and command time, and loads the register defaults.
// Backpressure
//   A finished result waits in the output register; the next item is still
//   taken, and a later result step holds until that register is free.
module rate_pi_current_controller
    import rpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_word_t            item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_word_t          result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [1:0]                axis_select_reg;
    logic signed [GAIN_W-1:0]  gain_p_reg;
    logic signed [GAIN_W-1:0]  gain_i_reg;
    logic [PERIOD_W-1:0]       loop_period_reg;
    logic [TIME_W-1:0]         timeout_reg;

    // Controller state
    logic signed [DATA_W-1:0]  rate_error_reg;
    logic signed [DATA_W-1:0]  integrator_reg;
    logic [TIME_W-1:0]         last_cmd_reg;

    // Sequencer and datapath
    logic [STEP_W-1:0]         pc_reg;
    logic [STEP_W-1:0]         pc_next;
    item_word_t                item_reg;
    logic signed [57:0]        prod_reg;
    logic signed [63:0]        acc_reg;
    logic [11:0]               quot_reg;
    logic                      result_valid_reg;
    logic                      result_valid_next;
    result_word_t              result_reg;

    ctrl_t                     ctrl;
    logic                      accept;
    logic                      emit;
    logic                      exec;
    logic                      stale;
    logic                      frame_match;
    logic signed [RAW_W-1:0]   raw_sel;
    logic signed [RAW_W:0]     raw_ext;
    logic [RAW_W:0]            raw_mag;
    logic signed [32:0]        mul_a;
    logic signed [24:0]        mul_b;
    logic signed [57:0]        product;
    logic [25:0]               div_x;
    logic [11:0]               div_q;
    logic [15:0]               div_r;
    logic [DATA_W-1:0]         err_mag;
    logic [TIME_W-1:0]         age;

    // Round to nearest (halves away from zero) after an arithmetic shift
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int k);
        logic signed [63:0] bias;
        bias = 64'sd1 <<< (k - 1);
        return (v + bias - $signed({63'd0, v[63]})) >>> k;
    endfunction

    // Clamp to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    assign ctrl   = ucode(pc_reg);
    assign accept = item_valid && !item_stall;
    assign emit   = (ctrl.alu == ALU_OUT) || (ctrl.alu == ALU_STALE);
    assign exec   = !(emit && result_valid_reg && result_stall);

    assign item_stall   = (pc_reg != STEP_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Branch conditions
    assign age         = item_reg.now_us - last_cmd_reg;
    assign stale       = age > timeout_reg;
    assign frame_match = (item_reg.frame_id == FRAME_ID_RATE)
                      && (item_reg.frame_length == FRAME_LEN_RATE);

    // Axis select, 3 behaves as z
    always_comb
    begin
        case (axis_select_reg)
            2'd0:    raw_sel = item_reg.rate_error_x;
            2'd1:    raw_sel = item_reg.rate_error_y;
            default: raw_sel = item_reg.rate_error_z;
        endcase
    end

    assign raw_ext = (RAW_W+1)'(raw_sel);
    assign raw_mag = raw_ext[RAW_W] ? 17'(-raw_ext) : 17'(raw_ext);

    // Shared multiplier operands
    always_comb
    begin
        unique case (ctrl.mul)
            MUL_KI_ERR:
            begin
                mul_a = 33'(rate_error_reg);
                mul_b = 25'(gain_i_reg);
            end
            MUL_KP_ERR:
            begin
                mul_a = 33'(rate_error_reg);
                mul_b = 25'(gain_p_reg);
            end
            MUL_PHI_LP:
            begin
                // upper half of p carries the sign
                mul_a = 33'($signed(acc_reg[39:20]));
                mul_b = $signed({1'b0, loop_period_reg});
            end
            MUL_PLO_LP:
            begin
                mul_a = $signed({13'd0, acc_reg[19:0]});
                mul_b = $signed({1'b0, loop_period_reg});
            end
            MUL_RAW_K:
            begin
                mul_a = $signed({16'd0, raw_mag});
                mul_b = 25'sd1000;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Rounded divide by 32767: estimate by shift, one correction
    assign div_x   = acc_reg[25:0] + 26'd16383;
    assign div_q   = {1'b0, div_x[25:15]};
    assign div_r   = {1'b0, div_x[14:0]} + {4'd0, div_q};
    assign err_mag = acc_reg[31:0] + {20'd0, quot_reg};

    // Step sequencing
    always_comb
    begin
        pc_next = pc_reg + 4'd1;
        unique case (ctrl.jmp)
            JMP_ACCEPT:  pc_next = accept ? ctrl.target : pc_reg;
            JMP_FRAME:   if (item_reg.kind == KIND_FRAME) pc_next = ctrl.target;
            JMP_STALE:   if (stale) pc_next = ctrl.target;
            JMP_SAT:     if (item_reg.drive_saturated) pc_next = ctrl.target;
            JMP_NOMATCH: if (!frame_match) pc_next = ctrl.target;
            JMP_ALWAYS:  pc_next = ctrl.target;
            default:     pc_next = pc_reg + 4'd1;
        endcase
        if (!exec)
            pc_next = pc_reg;
    end

    // Output register valid
    always_comb
    begin
        if (emit && exec)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= STEP_IDLE;
            result_valid_reg <= 1'b0;
            axis_select_reg  <= AXIS_RESET;
            gain_p_reg       <= '0;
            gain_i_reg       <= '0;
            loop_period_reg  <= PERIOD_RESET;
            timeout_reg      <= TIMEOUT_RESET;
            rate_error_reg   <= '0;
            integrator_reg   <= '0;
            last_cmd_reg     <= '0;
        end
        else
        begin
            pc_reg           <= pc_next;
            result_valid_reg <= result_valid_next;

            // Register writes
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_AXIS_SELECT:       axis_select_reg <= cfg_data[1:0];
                    REG_GAIN_PROPORTIONAL: gain_p_reg      <= cfg_data[GAIN_W-1:0];
                    REG_GAIN_INTEGRAL:     gain_i_reg      <= cfg_data[GAIN_W-1:0];
                    REG_LOOP_PERIOD:       loop_period_reg <= cfg_data[PERIOD_W-1:0];
                    REG_TIMEOUT_US:        timeout_reg     <= cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end

            // Integrator update
            if (exec && ctrl.alu == ALU_INTEG)
                integrator_reg <= sat32(64'(integrator_reg) + acc_reg);

            // Accepted command
            if (exec && ctrl.alu == ALU_ERR)
            begin
                rate_error_reg <= raw_ext[RAW_W] ? $signed(-err_mag) : $signed(err_mag);
                last_cmd_reg   <= item_reg.now_us;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;

        if (exec && ctrl.mul != MUL_NONE)
            prod_reg <= product;

        if (exec)
        begin
            case (ctrl.alu)
                ALU_RND16:      acc_reg <= rnd_shift(64'(prod_reg), 16);
                ALU_LOAD_SHL20: acc_reg <= 64'(prod_reg) <<< 20;
                ALU_ADD_PROD:   acc_reg <= acc_reg + 64'(prod_reg);
                ALU_RND24:      acc_reg <= rnd_shift(acc_reg, 24);
                ALU_LOAD:       acc_reg <= 64'(prod_reg);
                ALU_DIVQ:       quot_reg <= div_q + {11'd0, (div_r >= 16'd32767)};
                ALU_OUT:
                begin
                    result_reg.drive_mode        <= MODE_CURRENT;
                    result_reg.current_reference <= sat32(acc_reg + 64'(integrator_reg));
                end
                ALU_STALE:
                begin
                    result_reg.drive_mode        <= MODE_DISABLED;
                    result_reg.current_reference <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/rpc_checker.sv */
// Port-level checker for the rate PI controller, bound to the top level.
module rpc_checker
    import rpc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         item_valid,
    input logic         item_stall,
    input logic         result_valid,
    input logic         result_stall,
    input result_word_t result
);

    // A stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // An accepted item keeps the block busy the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input not stalled after accepting a word");

    // A new result only comes out of a busy period
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without work in progress");

    // Disabled drive carries a zero reference
    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.drive_mode == MODE_DISABLED)
            |-> result.current_reference == 32'sd0)
        else $error("nonzero reference in disabled mode");

endmodule

bind rate_pi_current_controller rpc_checker u_rpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
